[rtl/kdeq_pkg.sv]
// Package for the keypad debounce and event queue.
// Holds the sequencer state type, fixed widths and the key character map.
// No dependencies.
`timescale 1ns / 1ps

package kdeq_pkg;

    localparam int MASK_W     = 20;
    localparam int DEB_W      = 4;
    localparam int CODE_W     = 7;
    localparam int DROP_W     = 5;
    localparam int LEVEL_W    = 3;
    localparam int RC_W       = 3;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 4'd3;
    localparam logic [DROP_W-1:0] DROP_MAX       = 5'd31;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_WALK,
        ST_POP,
        ST_DONE
    } state_t;

    // Fixed 5x4 legend; anything outside it maps to zero.
    function automatic logic [CODE_W-1:0] char_map(
        input logic [RC_W-1:0] row,
        input logic [RC_W-1:0] col
    );
        logic [CODE_W-1:0] ch;
        ch = '0;
        case ({row, col})
            {3'd0, 3'd0}: ch = 7'h41; // A
            {3'd0, 3'd1}: ch = 7'h46; // F
            {3'd0, 3'd2}: ch = 7'h47; // G
            {3'd0, 3'd3}: ch = 7'h48; // H
            {3'd1, 3'd0}: ch = 7'h42; // B
            {3'd1, 3'd1}: ch = 7'h31; // 1
            {3'd1, 3'd2}: ch = 7'h32; // 2
            {3'd1, 3'd3}: ch = 7'h33; // 3
            {3'd2, 3'd0}: ch = 7'h43; // C
            {3'd2, 3'd1}: ch = 7'h34; // 4
            {3'd2, 3'd2}: ch = 7'h35; // 5
            {3'd2, 3'd3}: ch = 7'h36; // 6
            {3'd3, 3'd0}: ch = 7'h44; // D
            {3'd3, 3'd1}: ch = 7'h37; // 7
            {3'd3, 3'd2}: ch = 7'h38; // 8
            {3'd3, 3'd3}: ch = 7'h39; // 9
            {3'd4, 3'd0}: ch = 7'h45; // E
            {3'd4, 3'd1}: ch = 7'h2E; // .
            {3'd4, 3'd2}: ch = 7'h30; // 0
            {3'd4, 3'd3}: ch = 7'h4B; // K
            default:      ch = '0;
        endcase
        return ch;
    endfunction

endpackage

[rtl/keypad_debounce_event_queue_top.sv]
// Keypad debounce and event queue, top level.
// Sequencer, debounce registers, changed-key walker and event ring memory.
// Depends on kdeq_pkg.
`timescale 1ns / 1ps

// One transaction in gives one transaction out. A scan tick also walks each
// key position up to and including the highest changed key when the
// debounced mask moves. The walk is set by the single push port of the
// event ring: one key is examined and at most one event written per cycle.
// The input is stalled from acceptance until the result is loaded into the
// output register, which waits further only while the output side stalls.
// The ring holds QUEUE_DEPTH-1 events; events pushed into a full ring are
// dropped and counted in events_dropped for that tick. The debounce
// threshold deb_reg resets to 3.
module keypad_debounce_event_queue_top
    import kdeq_pkg::*;
#(
    parameter int ROWS        = 5,
    parameter int COLS        = 4,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [DEB_W-1:0]     cfg_wdata,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic [MASK_W-1:0]    scan_mask,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 event_valid,
    output logic [CODE_W-1:0]    key_code,
    output logic                 key_pressed,
    output logic [DROP_W-1:0]    events_dropped,
    output logic [LEVEL_W-1:0]   queue_level
);

    localparam int KEYS  = (ROWS * COLS < MASK_W) ? ROWS * COLS : MASK_W;
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int LVW   = (PW + 1 > LEVEL_W) ? PW + 1 : LEVEL_W;

    state_t                state_reg, state_next;
    logic                  mode_reg, mode_next;
    logic [KEYS-1:0]       raw_reg, raw_next;
    logic [KEYS-1:0]       cand_reg, cand_next;
    logic [DEB_W-1:0]      count_reg, count_next;
    logic [KEYS-1:0]       stable_reg, stable_next;
    logic [KEYS-1:0]       walk_reg, walk_next;
    logic [KEYS-1:0]       press_reg, press_next;
    logic [RC_W-1:0]       row_reg, row_next;
    logic [RC_W-1:0]       col_reg, col_next;
    logic [PW-1:0]         head_reg, head_next;
    logic [PW-1:0]         tail_reg, tail_next;
    logic [DROP_W-1:0]     drop_reg, drop_next;
    logic                  hit_reg, hit_next;
    logic [DEB_W-1:0]      deb_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic                  pressed_reg, pressed_next;
    logic [DROP_W-1:0]     dropped_reg, dropped_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;

    // Event ring storage
    logic [CODE_W-1:0]     queue_keys [QUEUE_DEPTH];
    logic                  queue_flags [QUEUE_DEPTH];
    logic [CODE_W-1:0]     rd_code_reg;
    logic                  rd_flag_reg;

    logic                  push_we;
    logic [CODE_W-1:0]     push_code;
    logic                  push_flag;
    logic                  rd_en;

    logic [PW-1:0]         head_inc;
    logic [PW-1:0]         tail_inc;
    logic [DEB_W-1:0]      count_bump;
    logic [PW:0]           level_raw;
    logic [LVW-1:0]        level_ext;
    logic                  accept_in;
    logic                  out_free;

    assign accept_in = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    assign head_inc = (head_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign level_raw = (head_reg >= tail_reg)
        ? (PW + 1)'({1'b0, head_reg} - {1'b0, tail_reg})
        : (PW + 1)'({1'b0, head_reg} + (PW + 1)'(QUEUE_DEPTH) - {1'b0, tail_reg});
    assign level_ext = LVW'(level_raw);

    assign count_bump = (count_reg < deb_reg) ? count_reg + 1'b1 : count_reg;

    assign push_code = char_map(row_reg, col_reg);
    assign push_flag = press_reg[0];

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        raw_next       = raw_reg;
        cand_next      = cand_reg;
        count_next     = count_reg;
        stable_next    = stable_reg;
        walk_next      = walk_reg;
        press_next     = press_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        drop_next      = drop_reg;
        hit_next       = hit_reg;
        push_we        = 1'b0;
        rd_en          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        ev_valid_next  = ev_valid_reg;
        code_next      = code_reg;
        pressed_next   = pressed_reg;
        dropped_next   = dropped_reg;
        level_next     = level_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    mode_next  = mode;
                    raw_next   = scan_mask[KEYS-1:0];
                    drop_next  = '0;
                    hit_next   = 1'b0;
                    state_next = (mode == MODE_POP) ? ST_POP : ST_TICK;
                end
            end

            ST_TICK:
            begin
                state_next = ST_DONE;
                if (raw_reg != cand_reg)
                begin
                    cand_next  = raw_reg;
                    count_next = DEB_W'(1);
                end
                else
                begin
                    count_next = count_bump;
                    if (count_bump >= deb_reg && stable_reg != cand_reg)
                    begin
                        walk_next   = stable_reg ^ cand_reg;
                        press_next  = cand_reg;
                        stable_next = cand_reg;
                        row_next    = '0;
                        col_next    = '0;
                        state_next  = ST_WALK;
                    end
                end
            end

            // One key position per cycle, lowest index first.
            ST_WALK:
            begin
                if (walk_reg[0])
                begin
                    if (head_inc == tail_reg)
                    begin
                        if (drop_reg != DROP_MAX)
                            drop_next = drop_reg + 1'b1;
                    end
                    else
                    begin
                        push_we   = 1'b1;
                        head_next = head_inc;
                    end
                end
                walk_next  = walk_reg >> 1;
                press_next = press_reg >> 1;
                if (col_reg == RC_W'(COLS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                if ((walk_reg >> 1) == '0)
                    state_next = ST_DONE;
            end

            ST_POP:
            begin
                if (head_reg != tail_reg)
                begin
                    rd_en     = 1'b1;
                    hit_next  = 1'b1;
                    tail_next = tail_inc;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ev_valid_next  = hit_reg;
                    code_next      = hit_reg ? rd_code_reg : '0;
                    pressed_next   = hit_reg && rd_flag_reg;
                    dropped_next   = drop_reg;
                    level_next     = level_ext[LEVEL_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cand_reg      <= '0;
            count_reg     <= '0;
            stable_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            deb_reg       <= DEBOUNCE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cand_reg      <= cand_next;
            count_reg     <= count_next;
            stable_reg    <= stable_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                deb_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        raw_reg      <= raw_next;
        walk_reg     <= walk_next;
        press_reg    <= press_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        drop_reg     <= drop_next;
        hit_reg      <= hit_next;
        ev_valid_reg <= ev_valid_next;
        code_reg     <= code_next;
        pressed_reg  <= pressed_next;
        dropped_reg  <= dropped_next;
        level_reg    <= level_next;
    end

    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            queue_keys[head_reg]  <= push_code;
            queue_flags[head_reg] <= push_flag;
        end
        if (rd_en)
        begin
            rd_code_reg <= queue_keys[tail_reg];
            rd_flag_reg <= queue_flags[tail_reg];
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_valid    = ev_valid_reg;
    assign key_code       = code_reg;
    assign key_pressed    = pressed_reg;
    assign events_dropped = dropped_reg;
    assign queue_level    = level_reg;

    // The sequencer holds off new transactions once one is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> in_stall)
        else $error("input not stalled after accept");

    // A push never lands on the oldest entry.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push_we |-> (head_inc != tail_reg))
        else $error("event ring overrun");

    // The key walk only runs for a scan tick.
    a_walk_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (mode_reg == MODE_TICK))
        else $error("key walk on a pop");

    // A popped event never reports drops.
    a_pop_no_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_valid) |-> (events_dropped == '0))
        else $error("drops reported on a pop");

endmodule
